// ===== sv/polynomial_multiply_add_macros.svh =====
// Assertion helpers for the checker of this block.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef POLYNOMIAL_MULTIPLY_ADD_MACROS_SVH
`define POLYNOMIAL_MULTIPLY_ADD_MACROS_SVH

// Same-cycle implication.
`define PMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pma_pkg.sv =====
package pma_pkg;

  localparam int unsigned MAX_DEGREE  = 15;
  localparam int unsigned COEFF_WIDTH = 32;
  localparam int unsigned DEPTH       = MAX_DEGREE + 1;
  localparam int unsigned SIDX_W      = $clog2(DEPTH);

  // Fixed field widths of the channels and registers
  localparam int unsigned DEG_W      = 4;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned RIDX_W     = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // Run counter spans the product length plus the product and partial-sum registers of the cells
  localparam int unsigned CNT_W = $clog2(2 * MAX_DEGREE + 3);

  typedef logic [COEFF_WIDTH-1:0] coeff_t;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_MUL    = 2'd2,
    ACT_ADD    = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEGREE_A = 1'b0,
    REG_DEGREE_B = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD
  } state_e;

  typedef struct packed {
    action_e                 action;
    logic [IDX_W-1:0]        index;
    logic signed [OUT_W-1:0] coeff_in;
  } in_item_t;

  typedef struct packed {
    logic [RIDX_W-1:0]       result_index;
    logic signed [OUT_W-1:0] result_coeff;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic adv;
    logic clr;
  } cell_ctrl_t;

  function automatic logic [DEG_W-1:0] sat_degree(logic [CFG_DATA_W-1:0] v);
    logic [DEG_W-1:0] d;
    d = DEG_W'(v);
    if (int'(d) > MAX_DEGREE) begin
      d = DEG_W'(MAX_DEGREE);
    end
    return d;
  endfunction

endpackage

// ===== sv/pma_if.sv =====
interface pma_in_if;
  logic               valid;
  logic               ready;
  pma_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pma_out_if;
  logic               valid;
  logic               ready;
  pma_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/pma_cell.sv =====
// One tap of the transposed convolution row: holds a coefficient of A,
// multiplies the broadcast B term and adds into the partial sum passed left.
module pma_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pma_pkg::cell_ctrl_t ctrl_i,
  input  logic                use_i,
  input  logic                ld_i,
  input  pma_pkg::coeff_t     ld_val_i,
  input  pma_pkg::coeff_t     x_i,
  input  pma_pkg::coeff_t     sum_i,
  output pma_pkg::coeff_t     sum_o,
  output pma_pkg::coeff_t     coef_o
);

  pma_pkg::coeff_t coef_q;
  pma_pkg::coeff_t prod_d, prod_q;
  pma_pkg::coeff_t sum_d, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (ld_i) begin
      coef_q <= ld_val_i;
    end
  end

  // taps above the configured degree contribute nothing
  assign prod_d = use_i ? pma_pkg::coeff_t'(coef_q * x_i) : '0;
  assign sum_d  = prod_q + sum_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      prod_q <= '0;
      sum_q  <= '0;
    end else if (ctrl_i.adv) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign coef_o = coef_q;

endmodule

// ===== sv/polynomial_multiply_add.sv =====
// Polynomial multiply/add. Holds A in a row of 16 multiply-accumulate cells
// and B in a register file; both clear to zero at reset. A load beat is
// dropped when its index is above the configured degree. A multiply beat
// streams B through the cell row one term per cycle unless the output
// stalls, and returns degree_a+degree_b+1 product terms, lowest degree
// first; each term passes a product register, then a partial-sum register
// in the row. An add beat returns max(degree_a,degree_b)+1 sums, one per
// cycle unless the output stalls. The last term of a run is flagged.
// Output backpressure stalls the whole row. A new beat is taken as soon as
// a run has handed its last term to the output register.
module polynomial_multiply_add (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pma_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pma_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  pma_in_if.sink                             in_i,
  pma_out_if.source                          out_o
);

  localparam int unsigned DEPTH  = pma_pkg::DEPTH;
  localparam int unsigned SIDX_W = pma_pkg::SIDX_W;
  localparam int unsigned CNT_W  = pma_pkg::CNT_W;
  localparam int unsigned RIDX_W = pma_pkg::RIDX_W;
  localparam int unsigned DEG_W  = pma_pkg::DEG_W;

  pma_pkg::state_e           state_q, state_d;
  logic [DEG_W-1:0]          deg_a_q, deg_b_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [RIDX_W-1:0]         n_q;
  pma_pkg::coeff_t           b_q [DEPTH];
  logic                      out_valid_q;
  pma_pkg::out_item_t        out_q;

  pma_pkg::coeff_t           sum_chain [DEPTH+1];
  pma_pkg::coeff_t           coef_a [DEPTH];
  pma_pkg::cell_ctrl_t       ctrl;
  pma_pkg::coeff_t           x;
  pma_pkg::coeff_t           ld_val;
  pma_pkg::coeff_t           add_a, add_b, emit_val;

  logic                      in_acc;
  logic                      in_ready;
  logic                      adv;
  logic                      emit;
  logic                      emit_last;
  logic [RIDX_W-1:0]         emit_idx;
  logic                      ld_a_ok, ld_b_ok;
  logic [RIDX_W-1:0]         n_mul, n_add;

  assign in_acc = in_i.valid && in_ready;
  assign adv    = (state_q != pma_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign ld_val = in_i.payload.coeff_in[pma_pkg::COEFF_WIDTH-1:0];

  assign ld_a_ok = in_acc && (in_i.payload.action == pma_pkg::ACT_LOAD_A) &&
                   (in_i.payload.index <= deg_a_q);
  assign ld_b_ok = in_acc && (in_i.payload.action == pma_pkg::ACT_LOAD_B) &&
                   (in_i.payload.index <= deg_b_q) && (int'(in_i.payload.index) < DEPTH);

  assign n_mul = RIDX_W'(deg_a_q) + RIDX_W'(deg_b_q);
  assign n_add = (deg_a_q > deg_b_q) ? RIDX_W'(deg_a_q) : RIDX_W'(deg_b_q);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_a_q <= '0;
      deg_b_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pma_pkg::REG_DEGREE_A: deg_a_q <= pma_pkg::sat_degree(cfg_data_i);
        pma_pkg::REG_DEGREE_B: deg_b_q <= pma_pkg::sat_degree(cfg_data_i);
        default: ;
      endcase
    end
  end

  // B coefficient store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        b_q[i] <= '0;
      end
    end else if (ld_b_ok) begin
      b_q[in_i.payload.index[SIDX_W-1:0]] <= ld_val;
    end
  end

  // cell row; partial sums move toward cell 0
  assign sum_chain[DEPTH] = '0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    pma_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .use_i    (j <= int'(deg_a_q)),
      .ld_i     (ld_a_ok && (int'(in_i.payload.index) == j)),
      .ld_val_i (ld_val),
      .x_i      (x),
      .sum_i    (sum_chain[j+1]),
      .sum_o    (sum_chain[j]),
      .coef_o   (coef_a[j])
    );
  end

  // B term fed to the row, zero past its degree
  always_comb begin
    x = '0;
    if ((state_q == pma_pkg::ST_MUL) && (cnt_q <= CNT_W'(deg_b_q))) begin
      x = b_q[cnt_q[SIDX_W-1:0]];
    end
  end

  always_comb begin
    add_a = (cnt_q <= CNT_W'(deg_a_q)) ? coef_a[cnt_q[SIDX_W-1:0]] : '0;
    add_b = (cnt_q <= CNT_W'(deg_b_q)) ? b_q[cnt_q[SIDX_W-1:0]] : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pma_pkg::ST_IDLE: begin
        if (in_acc && (in_i.payload.action == pma_pkg::ACT_MUL)) begin
          state_d = pma_pkg::ST_MUL;
        end else if (in_acc && (in_i.payload.action == pma_pkg::ACT_ADD)) begin
          state_d = pma_pkg::ST_ADD;
        end
      end
      pma_pkg::ST_MUL, pma_pkg::ST_ADD: begin
        if (adv && emit && emit_last) begin
          state_d = pma_pkg::ST_IDLE;
        end
      end
      default: state_d = pma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    ctrl.adv  = 1'b0;
    ctrl.clr  = 1'b0;
    emit      = 1'b0;
    emit_idx  = '0;
    emit_val  = '0;
    case (state_q)
      pma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.clr = in_i.valid && (in_i.payload.action == pma_pkg::ACT_MUL);
      end
      pma_pkg::ST_MUL: begin
        ctrl.adv = adv;
        // first term leaves cell 0 once B has passed the product and partial-sum registers
        emit     = (cnt_q >= CNT_W'(2));
        emit_idx = RIDX_W'(cnt_q - CNT_W'(2));
        emit_val = sum_chain[0];
      end
      pma_pkg::ST_ADD: begin
        emit     = 1'b1;
        emit_idx = RIDX_W'(cnt_q);
        emit_val = add_a + add_b;
      end
      default: ;
    endcase
  end

  assign emit_last = (emit_idx == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pma_pkg::ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        cnt_q <= '0;
        n_q   <= (in_i.payload.action == pma_pkg::ACT_MUL) ? n_mul : n_add;
      end else if (adv) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_q.result_index <= emit_idx;
      out_q.result_coeff <= pma_pkg::OUT_W'(signed'(emit_val));
      out_q.last         <= emit_last;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

// ===== sv/pma_checker.sv =====
`include "polynomial_multiply_add_macros.svh"

module pma_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input pma_pkg::in_item_t  in_payload_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input pma_pkg::out_item_t out_payload_i
);

  logic run_start;

  assign run_start = in_valid_i && in_ready_i &&
                     ((in_payload_i.action == pma_pkg::ACT_MUL) ||
                      (in_payload_i.action == pma_pkg::ACT_ADD));

  `PMA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output beat dropped while stalled")
  `PMA_ASSERT_IMPL(a_busy_mid_run, out_valid_i && !out_payload_i.last, !in_ready_i, "input taken in the middle of a run")
  `PMA_ASSERT_NEXT(a_run_blocks, run_start, !in_ready_i, "input taken right after a run started")
  `PMA_ASSERT_IMPL(a_idx_range, out_valid_i, int'(out_payload_i.result_index) <= 2 * pma_pkg::MAX_DEGREE, "result index out of range")

endmodule

bind polynomial_multiply_add pma_checker u_pma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_payload_i  (in_i.payload),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
